>>> hdl/psb_pkg.sv
// Shared types, request codes and default sizes of the periodic soft timer bank.
package psb_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CMD_DEPTH_DEF    = 2;
  localparam int RES_DEPTH_DEF    = 4;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_ENABLE   = 3'd1;
  localparam logic [2:0] REQ_STOP     = 3'd2;
  localparam logic [2:0] REQ_CONTINUE = 3'd3;
  localparam logic [2:0] REQ_QUERY    = 3'd4;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ENABLE,
    OP_STOP,
    OP_CONT,
    OP_QUERY
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } eng_state_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  channel;
    logic        ch_ok;
    logic [30:0] period_ms;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] fired_channel;
    logic       running;
    logic       last_fire;
  } res_t;

endpackage

>>> hdl/psb_fifo.sv
// Small first-in first-out word queue built from flip-flops.
module psb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/psb_front.sv
// Request front end: decode and classify each request word, drop those with no effect.
module psb_front
  import psb_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  channel_i,
  input  logic [30:0] period_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  cmd_t cmd_q, cmd_d;
  logic cmd_vld_q, cmd_vld_d;
  logic ch_ok, keep, accept, move;
  op_e  op;

  assign ch_ok  = (32'(channel_i) < NUM_CHANNELS);
  assign move   = cmd_vld_q && !cmd_full_i;
  assign full_o = cmd_vld_q && cmd_full_i;
  assign accept = push_i && !full_o;

  // Unused codes and writes to channels beyond the bank change nothing.
  always_comb begin
    op   = OP_TICK;
    keep = 1'b0;
    case (req_type_i)
      REQ_TICK:     begin op = OP_TICK;   keep = 1'b1;  end
      REQ_ENABLE:   begin op = OP_ENABLE; keep = ch_ok; end
      REQ_STOP:     begin op = OP_STOP;   keep = ch_ok; end
      REQ_CONTINUE: begin op = OP_CONT;   keep = ch_ok; end
      REQ_QUERY:    begin op = OP_QUERY;  keep = 1'b1;  end
      default:      begin op = OP_TICK;   keep = 1'b0;  end
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    cmd_vld_d = cmd_vld_q;
    if (accept) begin
      cmd_d.op        = op;
      cmd_d.channel   = channel_i;
      cmd_d.ch_ok     = ch_ok;
      cmd_d.period_ms = period_ms_i;
      cmd_d.now_ms    = now_ms_i;
      cmd_vld_d       = keep;
    end else if (move) begin
      cmd_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_push_o = cmd_vld_q;
  assign cmd_o      = cmd_q;

endmodule

>>> hdl/psb_engine.sv
// Back end: channel state, pipelined tick scan and result word generation.
module psb_engine
  import psb_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output res_t res_o,
  output logic res_push_o,
  input  logic res_full_i
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W = $clog2(NUM_CHANNELS + 1);

  eng_state_e state_q, state_d;

  logic [NUM_CHANNELS-1:0] run_q, run_d;
  logic [NUM_CHANNELS-1:0] per_vld_q, per_vld_d;
  logic [NUM_CHANNELS-1:0] stp_vld_q, stp_vld_d;

  logic [30:0] per_mem [NUM_CHANNELS];
  logic [31:0] stp_mem [NUM_CHANNELS];
  logic [30:0] per_rd_q;
  logic [31:0] stp_rd_q;
  logic        per_ok_q, stp_ok_q;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ev_vld_q, ev_vld_d;
  logic [CH_W-1:0]  ev_ch_q, ev_ch_d;
  logic [31:0]      now_q, now_d;
  logic             hold_vld_q, hold_vld_d;
  logic [CH_W-1:0]  hold_ch_q, hold_ch_d;

  logic [CH_W-1:0]  cmd_ch;
  logic             rd_en;
  logic [CH_W-1:0]  rd_addr;
  logic             per_we, stp_we;
  logic [CH_W-1:0]  wr_addr;
  logic [31:0]      stp_wdata;
  logic [30:0]      per_val;
  logic [31:0]      stp_val, elapsed;
  logic             fire_ev, stall, scan_left;

  assign cmd_ch    = CH_W'(cmd_i.channel);
  assign per_val   = per_ok_q ? per_rd_q : '0;
  assign stp_val   = stp_ok_q ? stp_rd_q : '0;
  assign elapsed   = now_q - stp_val;
  assign fire_ev   = ev_vld_q && run_q[ev_ch_q] && (elapsed >= {1'b0, per_val});
  assign stall     = fire_ev && hold_vld_q && res_full_i;
  assign scan_left = (idx_q != IDX_W'(NUM_CHANNELS));
  assign rd_addr   = idx_q[CH_W-1:0];

  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    per_vld_d  = per_vld_q;
    stp_vld_d  = stp_vld_q;
    idx_d      = idx_q;
    ev_vld_d   = ev_vld_q;
    ev_ch_d    = ev_ch_q;
    now_d      = now_q;
    hold_vld_d = hold_vld_q;
    hold_ch_d  = hold_ch_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{kind: KIND_FIRE, fired_channel: 4'(hold_ch_q), running: 1'b1,
                   last_fire: 1'b0};
    rd_en      = 1'b0;
    per_we     = 1'b0;
    stp_we     = 1'b0;
    wr_addr    = cmd_ch;
    stp_wdata  = cmd_i.now_ms;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              cmd_pop_o = 1'b1;
              now_d     = cmd_i.now_ms;
              idx_d     = '0;
              ev_vld_d  = 1'b0;
              state_d   = ST_SCAN;
            end
            OP_ENABLE: begin
              cmd_pop_o         = 1'b1;
              per_we            = 1'b1;
              stp_we            = 1'b1;
              per_vld_d[cmd_ch] = 1'b1;
              stp_vld_d[cmd_ch] = 1'b1;
              run_d[cmd_ch]     = 1'b1;
            end
            OP_STOP: begin
              cmd_pop_o     = 1'b1;
              run_d[cmd_ch] = 1'b0;
            end
            OP_CONT: begin
              cmd_pop_o     = 1'b1;
              run_d[cmd_ch] = 1'b1;
            end
            OP_QUERY: begin
              // Hold the query until the result queue has room.
              if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o      = '{kind: KIND_QUERY, fired_channel: cmd_i.channel,
                               running: cmd_i.ch_ok && run_q[cmd_ch], last_fire: 1'b1};
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // A fire is parked in the hold register so the final one can carry the last flag.
        if (fire_ev && hold_vld_q && !res_full_i) begin
          res_push_o = 1'b1;
        end
        if (fire_ev && !stall) begin
          stp_we             = 1'b1;
          wr_addr            = ev_ch_q;
          stp_wdata          = now_q;
          stp_vld_d[ev_ch_q] = 1'b1;
          hold_vld_d         = 1'b1;
          hold_ch_d          = ev_ch_q;
        end
        if (!stall) begin
          if (scan_left) begin
            rd_en    = 1'b1;
            ev_vld_d = 1'b1;
            ev_ch_d  = rd_addr;
            idx_d    = idx_q + 1'b1;
          end else begin
            ev_vld_d = 1'b0;
          end
        end
        if (!scan_left && !ev_vld_q) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = '{kind: KIND_FIRE, fired_channel: 4'(hold_ch_q), running: 1'b1,
                         last_fire: 1'b1};
          hold_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      run_q      <= '0;
      per_vld_q  <= '0;
      stp_vld_q  <= '0;
      idx_q      <= '0;
      ev_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_q      <= run_d;
      per_vld_q  <= per_vld_d;
      stp_vld_q  <= stp_vld_d;
      idx_q      <= idx_d;
      ev_vld_q   <= ev_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_ch_q   <= ev_ch_d;
    now_q     <= now_d;
    hold_ch_q <= hold_ch_d;
  end

  // Channel period and stamp memories, read data registered.
  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[wr_addr] <= cmd_i.period_ms;
    end
    if (stp_we) begin
      stp_mem[wr_addr] <= stp_wdata;
    end
    if (rd_en) begin
      per_rd_q <= per_mem[rd_addr];
      stp_rd_q <= stp_mem[rd_addr];
      per_ok_q <= per_vld_q[rd_addr];
      stp_ok_q <= stp_vld_q[rd_addr];
    end
  end

endmodule

>>> hdl/periodic_soft_timer_bank.sv
// Top level of the periodic soft timer bank: front end, command queue, engine, result queue.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------------
//  request  | req_type_i channel_i period_ms_i now_ms_i     | push, full  (push && !full)
//  result   | kind_o fired_channel_o running_o last_fire_o  | pop, empty  (pop && !empty)
//
// Enable, stop, continue and query words are each handled in the engine's idle state. A tick
// dequeues, then makes one memory read per channel through the single read port of the
// period and stamp memories, evaluates the last channel, closes the scan and emits the
// parked final fire. Reset clears run flags and the written marks of both memories, so
// unwritten entries read as zero. The engine stalls only when the result queue is full.
module periodic_soft_timer_bank
  import psb_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int CMD_DEPTH    = CMD_DEPTH_DEF,
  parameter int RES_DEPTH    = RES_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  channel_i,
  input  logic [30:0] period_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [3:0]  fired_channel_o,
  output logic        running_o,
  output logic        last_fire_o
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  // front end to command queue
  logic             fe_push;
  cmd_t             fe_cmd;
  logic             cmd_full;
  logic [CMD_W-1:0] fe_cmd_vec;

  // command queue to engine
  logic [CMD_W-1:0] cmd_head_vec;
  cmd_t             cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;

  // engine to result queue
  res_t             res_word;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_word_vec;
  logic [RES_W-1:0] res_head_vec;
  res_t             res_head;

  assign fe_cmd_vec   = fe_cmd;
  assign cmd_head     = cmd_t'(cmd_head_vec);
  assign res_word_vec = res_word;
  assign res_head     = res_t'(res_head_vec);

  // Decode requests and drop those that change nothing.
  psb_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .channel_i  (channel_i),
    .period_ms_i(period_ms_i),
    .now_ms_i   (now_ms_i),
    .cmd_push_o (fe_push),
    .cmd_o      (fe_cmd),
    .cmd_full_i (cmd_full)
  );

  // Decouple the front end from a long tick scan.
  psb_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .data_i (fe_cmd_vec),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head_vec),
    .empty_o(cmd_empty)
  );

  // Execute commands and scan channels on each tick.
  psb_engine #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_word),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // Hold results until the consumer pops them.
  psb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word_vec),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head_vec),
    .empty_o(empty)
  );

  assign kind_o          = res_head.kind;
  assign fired_channel_o = res_head.fired_channel;
  assign running_o       = res_head.running;
  assign last_fire_o     = res_head.last_fire;

  // The engine never offers a result word the queue cannot take.
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result word pushed into full queue");

  // The engine only dequeues a command that is there.
  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // A dequeued query answers in the same cycle, as the only and final word.
  a_query_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd_head.op == OP_QUERY) |->
      (res_push && res_word.kind == KIND_QUERY && res_word.last_fire))
    else $error("query dequeued without its answer");

  // Fire words always report the channel as running.
  a_fire_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_word.kind == KIND_FIRE) |-> res_word.running)
    else $error("fire word without running flag");

endmodule
